/* src/lprd_pkg.sv */
`default_nettype none

package lprd_pkg;

  // Result kinds as seen on the output channel.
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_TRUNCATED = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_LENGTH  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_DROP    = 3'b100
  } phase_e;

  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCountW  = $clog2(QDepth + 1);
  localparam int unsigned LenW     = 32;
  localparam int unsigned LenByteW = 3;

  localparam logic [7:0] ContMask    = 8'h80;
  localparam logic [7:0] Low7Mask    = 8'h7f;
  localparam int unsigned TopShift   = 28;
  localparam int unsigned DigitBits  = 7;
  localparam logic [LenByteW-1:0] LastLenByte = LenByteW'(4);

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      payload;
    logic            record_last;
    logic [LenW-1:0] record_length;
  } result_t;

  // Up to two results per parsed byte, pushed into the result queue together.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

`default_nettype wire

/* src/lprd_if.sv */
`default_nettype none

interface lprd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface lprd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload;
  logic        record_last;
  logic [31:0] record_length;

  modport source (output valid, output kind, output payload, output record_last,
                  output record_length, input ready);
  modport sink (input valid, input kind, input payload, input record_last,
                input record_length, output ready);
endinterface

`default_nettype wire

/* src/lprd_parser.sv */
`default_nettype none

module lprd_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  lprd_in_if.sink             in_i,
  input  wire logic           space_ok_i,
  output lprd_pkg::push_t     push_o
);
  import lprd_pkg::*;

  logic       stage_valid_q;
  logic [7:0] stage_byte_q;
  logic       stage_eob_q;
  logic       fire;
  logic       in_fire;

  phase_e               phase_q, phase_d;
  logic [LenW-1:0]      acc_q, acc_d;
  logic [LenByteW-1:0]  cnt_q, cnt_d;
  logic [LenW-1:0]      remaining_q, remaining_d;
  logic [LenW-1:0]      cur_len_q, cur_len_d;

  logic [LenW-1:0] digit;
  logic [LenW-1:0] acc_new;
  logic            cont;
  push_t           push;

  assign fire      = stage_valid_q && space_ok_i;
  assign in_i.ready = !stage_valid_q || space_ok_i;
  assign in_fire   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      stage_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_byte_q <= in_i.data_byte;
      stage_eob_q  <= in_i.end_of_buffer;
    end
  end

  assign cont = (stage_byte_q & ContMask) != 8'h00;

  // The fifth length byte contributes only its low nibble at the top.
  always_comb begin
    digit = LenW'(stage_byte_q & Low7Mask);
    case (cnt_q[1:0])
      2'd0:    digit = digit;
      2'd1:    digit = digit << DigitBits;
      2'd2:    digit = digit << (2 * DigitBits);
      default: digit = digit << (3 * DigitBits);
    endcase
    if (cnt_q[2]) begin
      digit = LenW'(stage_byte_q[3:0]) << TopShift;
    end
    acc_new = acc_q | digit;
  end

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    remaining_d = remaining_q;
    cur_len_d   = cur_len_q;
    push        = '0;
    push.r0.kind = KIND_DATA;
    push.r1.kind = KIND_DATA;

    unique case (phase_q)
      PH_LENGTH: begin
        if (cnt_q >= LastLenByte && cont) begin
          push.v0      = 1'b1;
          push.r0.kind = KIND_MALFORMED;
          acc_d        = '0;
          cnt_d        = '0;
          phase_d      = stage_eob_q ? PH_LENGTH : PH_DROP;
        end else if (cont) begin
          acc_d = acc_new;
          cnt_d = cnt_q + LenByteW'(1);
          if (stage_eob_q) begin
            push.v0      = 1'b1;
            push.r0.kind = KIND_TRUNCATED;
            acc_d        = '0;
            cnt_d        = '0;
          end
        end else begin
          acc_d = '0;
          cnt_d = '0;
          if (acc_new == '0) begin
            push.v0             = 1'b1;
            push.r0.kind        = KIND_EMPTY;
            push.r0.record_last = 1'b1;
          end else if (stage_eob_q) begin
            push.v0               = 1'b1;
            push.r0.kind          = KIND_TRUNCATED;
            push.r0.record_length = acc_new;
          end else begin
            phase_d     = PH_PAYLOAD;
            remaining_d = acc_new;
            cur_len_d   = acc_new;
          end
        end
      end
      PH_PAYLOAD: begin
        push.v0               = 1'b1;
        push.r0.kind          = KIND_DATA;
        push.r0.payload       = stage_byte_q;
        push.r0.record_length = cur_len_q;
        if (remaining_q <= LenW'(1)) begin
          push.r0.record_last = 1'b1;
          phase_d             = PH_LENGTH;
        end else begin
          remaining_d = remaining_q - LenW'(1);
          if (stage_eob_q) begin
            // Record cut off by the end of the buffer: report after the byte.
            push.v1               = 1'b1;
            push.r1.kind          = KIND_TRUNCATED;
            push.r1.record_length = cur_len_q;
            phase_d               = PH_LENGTH;
          end
        end
      end
      default: begin
        if (stage_eob_q) begin
          phase_d = PH_LENGTH;
          acc_d   = '0;
          cnt_d   = '0;
        end
      end
    endcase

    if (!fire) begin
      push.v0 = 1'b0;
      push.v1 = 1'b0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LENGTH;
      acc_q       <= '0;
      cnt_q       <= '0;
      remaining_q <= '0;
      cur_len_q   <= '0;
    end else if (fire) begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      remaining_q <= remaining_d;
      cur_len_q   <= cur_len_d;
    end
  end

endmodule

`default_nettype wire

/* src/lprd_result_queue.sv */
`default_nettype none

module lprd_result_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  lprd_pkg::push_t push_i,
  output logic            space_ok_o,
  lprd_out_if.source      out_o
);
  import lprd_pkg::*;

  result_t            entries_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q;
  logic [QPtrW-1:0]   rd_ptr_q;
  logic [QCountW-1:0] count_q;
  logic [QPtrW-1:0]   wr_ptr_next;
  logic               pop;
  logic [1:0]         n_push;
  result_t            head;

  assign wr_ptr_next = wr_ptr_q + QPtrW'(1);
  assign pop         = out_o.valid && out_o.ready;
  assign n_push      = {1'b0, push_i.v0} + {1'b0, push_i.v1};
  // Room for a full pair of results is required before a byte is parsed.
  assign space_ok_o  = count_q <= QCountW'(QDepth - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      entries_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      entries_q[wr_ptr_next] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      count_q <= count_q + QCountW'(n_push) - QCountW'(pop);
    end
  end

  assign head                = entries_q[rd_ptr_q];
  assign out_o.valid         = count_q != '0;
  assign out_o.kind          = head.kind;
  assign out_o.payload       = head.payload;
  assign out_o.record_last   = head.record_last;
  assign out_o.record_length = head.record_length;

endmodule

`default_nettype wire

/* src/length_prefixed_record_deframer_top.sv */
// Length-prefixed record deframer.
// Input channel in_i carries one buffer byte per beat with an end_of_buffer
// flag on the last byte. Output channel out_o carries result beats: payload
// bytes tagged with their record length and a last mark, empty-record marks,
// and truncation or malformed-length errors.
// An accepted byte is held in an input register, parsed there, and its
// results are written into a four-entry result queue. The first result is
// presented on out_o once it has passed the input register and has been
// written into the queue.
// One byte is accepted per cycle in steady state while the queue has room
// for two results. A byte that ends a buffer in the middle of a payload
// yields two result beats, which drain from the queue one per cycle while
// the receiver is ready. The parser advances only when the queue has room
// for two results, so a stalled receiver fills the queue and then deasserts
// in_i.ready. Reset clears the queue and returns the parser to the start of
// a length prefix; results still queued at reset are discarded.
`default_nettype none

module length_prefixed_record_deframer_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lprd_in_if.sink    in_i,
  lprd_out_if.source out_o
);
  import lprd_pkg::*;

  push_t push;
  logic  space_ok;

  lprd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  lprd_result_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_ok_o (space_ok),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;
  import lprd_pkg::*;

  // Tracks the parser state for every accepted byte and holds the results
  // that the block owes us, oldest first.
  class record_checker;
    phase_e          phase;
    logic [LenW-1:0] len_acc;
    logic [2:0]      len_bytes;
    logic [LenW-1:0] bytes_left;
    logic [LenW-1:0] record_len;
    result_t         expected_results[$];
    int unsigned     mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      phase      = PH_LENGTH;
      len_acc    = '0;
      len_bytes  = '0;
      bytes_left = '0;
      record_len = '0;
    endfunction

    function void owe(kind_e k, logic [7:0] p, logic l, logic [LenW-1:0] n);
      result_t r;
      r.kind          = k;
      r.payload       = p;
      r.record_last   = l;
      r.record_length = n;
      expected_results.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b, logic eob);
      logic [LenW-1:0] n;
      logic            fin;
      case (phase)
        PH_LENGTH: begin
          if (len_bytes >= LastLenByte) begin
            // Only the low nibble of a fifth length byte counts.
            len_acc |= LenW'(b[3:0]) << TopShift;
            if ((b & ContMask) != 0) begin
              owe(KIND_MALFORMED, 8'h00, 1'b0, '0);
              if (eob) restart();
              else phase = PH_DROP;
              return;
            end
          end else begin
            len_acc |= LenW'(b & Low7Mask) << (DigitBits * len_bytes);
            if ((b & ContMask) != 0) begin
              len_bytes++;
              if (eob) begin
                owe(KIND_TRUNCATED, 8'h00, 1'b0, '0);
                restart();
              end
              return;
            end
          end
          n         = len_acc;
          len_acc   = '0;
          len_bytes = '0;
          if (n == 0) begin
            owe(KIND_EMPTY, 8'h00, 1'b1, '0);
            if (eob) restart();
          end else if (eob) begin
            owe(KIND_TRUNCATED, 8'h00, 1'b0, n);
            restart();
          end else begin
            phase      = PH_PAYLOAD;
            bytes_left = n;
            record_len = n;
          end
        end
        PH_PAYLOAD: begin
          fin = (bytes_left <= 1);
          owe(KIND_DATA, b, fin, record_len);
          if (fin) begin
            restart();
          end else begin
            bytes_left--;
            if (eob) begin
              owe(KIND_TRUNCATED, 8'h00, 1'b0, record_len);
              restart();
            end
          end
        end
        default: begin
          if (eob) restart();
        end
      endcase
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d payload %0h",
                 $time, got.kind, got.payload);
        $display("%0t:   actual last %0b len %0h", $time, got.record_last,
                 got.record_length);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("payload", 32'(want.payload), 32'(got.payload));
      compare_field("record_last", 32'(want.record_last), 32'(got.record_last));
      compare_field("record_length", want.record_length, got.record_length);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  lprd_in_if  in_if ();
  lprd_out_if out_if ();

  length_prefixed_record_deframer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  record_checker sb = new();
  result_t       seen;
  logic [7:0]    buf_q[$];
  int unsigned   beats_sent;
  int unsigned   in_idle_pct  = 0;
  int unsigned   out_idle_pct = 0;

  // Both clocked processes read handshake signals right after the edge,
  // before any nonblocking update of that edge lands.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen.kind          = kind_e'(out_if.kind);
      seen.payload       = out_if.payload;
      seen.record_last   = out_if.record_last;
      seen.record_length = out_if.record_length;
      sb.check_result(seen);
    end
  end

  initial begin
    forever begin
      if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send_beat(logic [7:0] b, logic eob);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= b;
    in_if.end_of_buffer <= eob;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_byte(b, eob);
    beats_sent++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < buf_q.size(); i++) send_beat(buf_q[i], i == buf_q.size() - 1);
    buf_q.delete();
  endtask

  // Appends one record, possibly with a padded length prefix; a cut record
  // stops somewhere inside its prefix or payload.
  task automatic add_record(bit cut);
    logic [31:0] n;
    logic [7:0]  rec[$];
    int          r;
    int          nb;
    int          keep;
    r = $urandom_range(0, 99);
    if (r < 10)      n = 0;
    else if (r < 78) n = $urandom_range(1, 8);
    else if (r < 92) n = $urandom_range(9, 300);
    else begin
      n   = $urandom();
      cut = 1'b1;
    end
    nb = 1;
    while (nb < 5 && (n >> (DigitBits * nb)) != 0) nb++;
    if ($urandom_range(0, 9) == 0) begin
      nb += int'($urandom_range(1, 2));
      if (nb > 5) nb = 5;
    end
    for (int i = 0; i < nb; i++) begin
      if (i == 4) rec.push_back({1'b0, 3'($urandom()), n[31:28]});
      else rec.push_back((8'(n >> (DigitBits * i)) & Low7Mask) |
                         ((i < nb - 1) ? ContMask : 8'h00));
    end
    for (int i = 0; i < ((n > 12) ? 12 : int'(n)); i++) rec.push_back(8'($urandom()));
    keep = rec.size();
    if (cut && rec.size() > 1) keep = $urandom_range(1, rec.size() - 1);
    for (int i = 0; i < keep; i++) buf_q.push_back(rec[i]);
  endtask

  function automatic int unsigned pick_idle();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 20;
      default: return 50;
    endcase
  endfunction

  initial begin
    int unsigned nrec;
    int          r;
    bit          cut;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.data_byte     <= 8'h00;
    in_if.end_of_buffer <= 1'b0;
    beats_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty record, then a one-byte record.
    send_beat(8'h00, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'hff, 1'b0);
    // Empty record that ends the buffer.
    send_beat(8'h00, 1'b1);
    // Buffer ends inside a length prefix.
    send_beat(8'h80, 1'b1);
    // Buffer ends right after a two-byte length.
    send_beat(8'h85, 1'b0);
    send_beat(8'h01, 1'b1);
    // Buffer ends inside a payload.
    send_beat(8'h04, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(8'haa, 1'b1);
    // Five-byte length with the dropped bits of the fifth byte set.
    send_beat(8'hff, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(8'h7f, 1'b0);
    send_beat(8'h5a, 1'b1);
    // Continuation on the fifth byte, then bytes dropped up to the buffer end.
    send_beat(8'h80, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h81, 1'b0);
    send_beat(8'h12, 1'b0);
    send_beat(8'h34, 1'b1);
    // Malformed length on the byte that ends the buffer.
    send_beat(8'h80, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'hf0, 1'b1);

    while (beats_sent < 750) begin
      if (beats_sent < 620) begin
        in_idle_pct  = pick_idle();
        out_idle_pct = pick_idle();
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      r = $urandom_range(0, 99);
      if (r < 12) begin
        repeat ($urandom_range(1, 8)) buf_q.push_back(8'($urandom()));
      end else if (r < 18) begin
        if ($urandom_range(0, 1) == 1) add_record(1'b0);
        repeat (4) buf_q.push_back(ContMask | 8'($urandom()));
        buf_q.push_back(ContMask | 8'($urandom()));
        repeat ($urandom_range(0, 4)) buf_q.push_back(8'($urandom()));
      end else begin
        nrec = $urandom_range(1, 4);
        cut  = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < nrec; i++) add_record(cut && i == nrec - 1);
      end
      send_buffer();
    end
    in_if.valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire
